// ===== rtl/core/fmp_pkg.sv =====
// Shared types, phase and status codes, and the field width table of the message parser.
package fmp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FbcW    = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [CountW-1:0] MAX_LEN_RESET = 32'd16777216;

  // Register indexes, taken from paddr[2].
  localparam logic REG_MAX_LEN = 1'b0;

  // Parse phases; a field phase equals the code of the token it emits.
  localparam logic [CodeW-1:0] PH_TYPE      = 5'd0;
  localparam logic [CodeW-1:0] PH_REJECT    = 5'd7;
  localparam logic [CodeW-1:0] PH_HINT      = 5'd8;
  localparam logic [CodeW-1:0] PH_ENT_COUNT = 5'd9;
  localparam logic [CodeW-1:0] PH_ENT_TERM  = 5'd10;
  localparam logic [CodeW-1:0] PH_ENT_TYPE  = 5'd12;
  localparam logic [CodeW-1:0] PH_ENT_LEN   = 5'd13;
  localparam logic [CodeW-1:0] PH_ENT_BYTE  = 5'd14;
  localparam logic [CodeW-1:0] PH_SNAP_TERM = 5'd15;
  localparam logic [CodeW-1:0] PH_SNAP_LEN  = 5'd17;
  localparam logic [CodeW-1:0] PH_SNAP_BYTE = 5'd18;
  localparam logic [CodeW-1:0] PH_CTX_LEN   = 5'd19;
  localparam logic [CodeW-1:0] PH_CTX_BYTE  = 5'd20;
  localparam logic [CodeW-1:0] PH_DONE      = 5'd21;
  localparam logic [CodeW-1:0] PH_PREFIX    = 5'd22;

  localparam logic [CodeW-1:0] CODE_STATUS = 5'd21;

  localparam logic [StatusW-1:0] ST_BUSY  = 2'd0;
  localparam logic [StatusW-1:0] ST_OK    = 2'd1;
  localparam logic [StatusW-1:0] ST_TRUNC = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD   = 2'd3;

  localparam logic [1:0] PREFIX_LAST = 2'd3;

  typedef struct packed {
    logic [CodeW-1:0]  phase;
    logic [FbcW-1:0]   fbc;
    logic [ValueW-1:0] shift;
    logic [CountW-1:0] body_rem;
    logic [CountW-1:0] blob_rem;
    logic [CountW-1:0] ent_rem;
    logic [CountW-1:0] ent_cnt;
    logic              err;
    logic              halted;
  } fmp_state_t;

  typedef struct packed {
    logic               valid;
    logic [CodeW-1:0]   code;
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  ent;
    logic               last;
    logic               done;
    logic [StatusW-1:0] status;
  } fmp_token_t;

  // Byte count of each fixed field, modulo eight (an eight-byte field completes at zero).
  function automatic logic [FbcW-1:0] field_width(input logic [CodeW-1:0] ph);
    logic [FbcW-1:0] w;
    unique case (ph)
      PH_TYPE, PH_REJECT, PH_ENT_TYPE:                   w = 3'd1;
      PH_ENT_COUNT, PH_ENT_LEN, PH_SNAP_LEN, PH_CTX_LEN: w = 3'd4;
      default:                                           w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/framed_message_parser_core.sv =====
// Byte-serial parser for length-prefixed messages: input register, parse state and result register.
// One received byte is accepted per clock and any token it produces is presented on the result
// port after passing the input register and the result register: the byte is held in the input
// register, the parse step updates the frame state, and any token lands in the result register.
// Sustained rate is one byte per cycle; it is set only by the result register: while a token
// waits on out_tready the next byte stays in the input register, and the input side stalls once
// that register is full. A frame opens with a 4-byte little-endian body length; a length of zero
// or above max_frame_length yields one status token with frame_done set and status 3, and the
// parser then ignores all bytes until reset. Every token of a frame that ends with status 2 is
// to be dropped.
module framed_message_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [63:0] field_value, [95:64] entry_number, [96] blob_last, [98:97] frame_status, rest zero
  output logic [103:0]                  out_tdata,
  output logic [4:0]                    out_tuser,  // [4:0] field_code
  output logic                          out_tlast,  // frame_done
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fmp_pkg::AddrW-1:0]     cfg_paddr,
  input  logic [fmp_pkg::DataW-1:0]     cfg_pwdata,
  output logic [fmp_pkg::DataW-1:0]     cfg_prdata,
  output logic                          cfg_pready
);

  logic [7:0]              in_byte_r;
  logic                    in_valid_r;
  logic                    advance;
  logic [31:0]             max_len;
  fmp_pkg::fmp_state_t     st_r;
  fmp_pkg::fmp_state_t     st_nxt;
  fmp_pkg::fmp_token_t     tok;
  fmp_pkg::fmp_token_t     out_tok_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;

  fmp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  fmp_step u_step (
    .st      (st_r),
    .rx_byte (in_byte_r),
    .max_len (max_len),
    .st_nxt  (st_nxt),
    .tok     (tok)
  );

  // The held byte is parsed whenever the result register is free or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: fmp_pkg::PH_PREFIX, default: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid_nxt = advance ? tok.valid : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok.valid) begin
      out_tok_r <= tok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_tok_r.code;
  assign out_tlast  = out_tok_r.done;
  assign out_tdata  = {5'd0, out_tok_r.status, out_tok_r.last, out_tok_r.ent, out_tok_r.value};

  a_halt_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.halted) |-> out_valid_r && out_tok_r.done
                           && (out_tok_r.status == fmp_pkg::ST_BAD))
    else $error("halt without a bad-length token");

  a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tok_r.done |-> out_tok_r.status != fmp_pkg::ST_BUSY)
    else $error("frame end token carries no status");

  a_blob_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tok_r.last |-> (out_tok_r.code == fmp_pkg::PH_ENT_BYTE)
                                      || (out_tok_r.code == fmp_pkg::PH_SNAP_BYTE)
                                      || (out_tok_r.code == fmp_pkg::PH_CTX_BYTE))
    else $error("blob_last on a non-blob token");

  a_err_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.err |-> st_r.phase != fmp_pkg::PH_PREFIX)
    else $error("frame error outside a frame body");

endmodule

// ===== rtl/core/fmp_cfg.sv =====
// APB register block holding the maximum frame length.
module fmp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fmp_pkg::AddrW-1:0]      cfg_paddr,
  input  logic [fmp_pkg::DataW-1:0]      cfg_pwdata,
  output logic [fmp_pkg::DataW-1:0]      cfg_prdata,
  output logic                           cfg_pready,
  output logic [fmp_pkg::CountW-1:0]     max_len
);

  logic [fmp_pkg::CountW-1:0] max_len_r;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == fmp_pkg::REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= fmp_pkg::MAX_LEN_RESET;
    end else if (wr_en) begin
      max_len_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == fmp_pkg::REG_MAX_LEN) ? max_len_r : '0;
  assign max_len = max_len_r;

endmodule

// ===== rtl/core/fmp_step.sv =====
// Next-state and token logic for one received byte.
module fmp_step (
  input  fmp_pkg::fmp_state_t            st,
  input  logic [fmp_pkg::ByteW-1:0]      rx_byte,
  input  logic [fmp_pkg::CountW-1:0]     max_len,
  output fmp_pkg::fmp_state_t            st_nxt,
  output fmp_pkg::fmp_token_t            tok
);

  logic [fmp_pkg::ValueW-1:0]  merged;
  logic [fmp_pkg::FbcW-1:0]    fbc_inc;
  logic [fmp_pkg::FbcW-1:0]    fw;
  logic [fmp_pkg::CountW-1:0]  body_dec;
  logic [fmp_pkg::CountW-1:0]  blob_dec;
  logic [fmp_pkg::CountW-1:0]  ent_dec;
  logic [fmp_pkg::CountW-1:0]  plen;
  logic [fmp_pkg::CodeW-1:0]   ent_next_ph;
  logic                        has;
  logic                        is_blob;

  always_comb begin
    merged = st.shift;
    for (int i = 0; i < 8; i++) begin
      if (st.fbc == i[fmp_pkg::FbcW-1:0]) begin
        merged[8*i +: 8] = st.shift[8*i +: 8] | rx_byte;
      end
    end
  end

  assign fbc_inc  = st.fbc + 3'd1;
  assign fw       = fmp_pkg::field_width(st.phase);
  assign body_dec = st.body_rem - 32'd1;
  assign blob_dec = st.blob_rem - 32'd1;
  assign ent_dec  = st.ent_rem - 32'd1;
  assign plen     = merged[31:0];
  assign ent_next_ph = (ent_dec != '0) ? fmp_pkg::PH_ENT_TERM : fmp_pkg::PH_SNAP_TERM;
  assign is_blob  = (st.phase == fmp_pkg::PH_ENT_BYTE) || (st.phase == fmp_pkg::PH_SNAP_BYTE)
                    || (st.phase == fmp_pkg::PH_CTX_BYTE);

  always_comb begin
    st_nxt     = st;
    tok        = '0;
    tok.code   = fmp_pkg::CODE_STATUS;
    tok.status = fmp_pkg::ST_BUSY;
    has        = 1'b0;
    if (!st.halted) begin
      if (st.phase > fmp_pkg::PH_DONE) begin
        // Little-endian length prefix.
        if (st.fbc[1:0] != fmp_pkg::PREFIX_LAST) begin
          st_nxt.shift = merged;
          st_nxt.fbc   = fbc_inc;
        end else begin
          st_nxt.shift = '0;
          st_nxt.fbc   = '0;
          if ((plen == '0) || (plen > max_len)) begin
            st_nxt.halted = 1'b1;
            tok.valid     = 1'b1;
            tok.value     = {32'd0, plen};
            tok.done      = 1'b1;
            tok.status    = fmp_pkg::ST_BAD;
          end else begin
            st_nxt.body_rem = plen;
            st_nxt.phase    = fmp_pkg::PH_TYPE;
            st_nxt.err      = 1'b0;
          end
        end
      end else begin
        st_nxt.body_rem = body_dec;
        if (!st.err && (st.phase < fmp_pkg::PH_DONE)) begin
          if ((st.phase >= fmp_pkg::PH_ENT_TERM) && (st.phase <= fmp_pkg::PH_ENT_BYTE)) begin
            tok.ent = st.ent_cnt;
          end
          tok.code = st.phase;
          if (is_blob) begin
            has             = 1'b1;
            tok.value       = {56'd0, rx_byte};
            st_nxt.blob_rem = blob_dec;
            tok.last        = (blob_dec == '0);
            if (blob_dec == '0) begin
              if (st.phase == fmp_pkg::PH_ENT_BYTE) begin
                st_nxt.ent_cnt = st.ent_cnt + 32'd1;
                st_nxt.ent_rem = ent_dec;
                st_nxt.phase   = ent_next_ph;
              end else begin
                st_nxt.phase = st.phase + 5'd1;
              end
            end
          end else begin
            st_nxt.shift = merged;
            st_nxt.fbc   = fbc_inc;
            if (fbc_inc == fw) begin
              has          = 1'b1;
              tok.value    = merged;
              st_nxt.shift = '0;
              st_nxt.fbc   = '0;
              if (st.phase == fmp_pkg::PH_REJECT) begin
                tok.value    = {63'd0, (merged != '0)};
                st_nxt.phase = fmp_pkg::PH_HINT;
              end else if (st.phase == fmp_pkg::PH_ENT_COUNT) begin
                st_nxt.ent_rem = merged[31:0];
                st_nxt.ent_cnt = '0;
                st_nxt.phase   = (merged[31:0] != '0) ? fmp_pkg::PH_ENT_TERM
                                                      : fmp_pkg::PH_SNAP_TERM;
              end else if ((st.phase == fmp_pkg::PH_ENT_LEN)
                           || (st.phase == fmp_pkg::PH_SNAP_LEN)
                           || (st.phase == fmp_pkg::PH_CTX_LEN)) begin
                // A blob longer than the rest of the frame marks the frame truncated.
                if (merged > {32'd0, body_dec}) begin
                  st_nxt.err = 1'b1;
                end else begin
                  st_nxt.blob_rem = merged[31:0];
                  if (merged != '0) begin
                    st_nxt.phase = st.phase + 5'd1;
                  end else if (st.phase == fmp_pkg::PH_ENT_LEN) begin
                    st_nxt.ent_cnt = st.ent_cnt + 32'd1;
                    st_nxt.ent_rem = ent_dec;
                    st_nxt.phase   = ent_next_ph;
                  end else begin
                    st_nxt.phase = st.phase + 5'd2;
                  end
                end
              end else begin
                st_nxt.phase = st.phase + 5'd1;
              end
            end
          end
        end
        if (body_dec == '0) begin
          tok.valid  = 1'b1;
          tok.done   = 1'b1;
          tok.status = ((st_nxt.phase == fmp_pkg::PH_DONE) && !st_nxt.err)
                       ? fmp_pkg::ST_OK : fmp_pkg::ST_TRUNC;
          if ((tok.status == fmp_pkg::ST_TRUNC) || !has) begin
            tok.code  = fmp_pkg::CODE_STATUS;
            tok.value = '0;
            tok.ent   = '0;
            tok.last  = 1'b0;
          end
          st_nxt.phase    = fmp_pkg::PH_PREFIX;
          st_nxt.fbc      = '0;
          st_nxt.shift    = '0;
          st_nxt.blob_rem = '0;
          st_nxt.ent_rem  = '0;
          st_nxt.ent_cnt  = '0;
          st_nxt.err      = 1'b0;
        end else begin
          tok.valid = has;
        end
      end
    end
  end

endmodule

// ===== tb/sv/framed_message_parser_core_test.sv =====
// Self-checking testbench for the framed message parser core: random frames against a predictor.
`timescale 1ns / 1ps

module framed_message_parser_core_test;
  import fmp_pkg::*;

  localparam logic [AddrW-1:0] ADDR_MAX_LEN = 3'd0;  // register index 0
  localparam logic [AddrW-1:0] ADDR_SPARE   = 3'd4;  // register index 1, not implemented
  localparam logic [CodeW-1:0] CODE_ENT_TYPE = 5'd12;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MIX_BYTES    = 380;

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [ValueW-1:0]  value;
    logic [CountW-1:0]  ent;
    logic               last;
    logic               done;
    logic [StatusW-1:0] status;
  } parse_token_t;

  typedef enum int {
    FR_EXACT, FR_TRAILING, FR_TRUNCATED, FR_BLOB_OVERRUN, FR_HUGE_COUNT, FR_NOISE
  } frame_kind_t;

  typedef enum int {HALT_ZERO_LEN, HALT_OVER_LIMIT, HALT_LIMIT_ZERO} halt_cause_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [4:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [DataW-1:0] cfg_pwdata = '0;
  logic [DataW-1:0] cfg_prdata;
  logic         cfg_pready;

  framed_message_parser_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted parser state and register copy.
  logic [CountW-1:0] max_len       = MAX_LEN_RESET;
  logic [CodeW-1:0]  st_phase      = PH_PREFIX;
  logic [FbcW-1:0]   st_fbc        = '0;
  logic [ValueW-1:0] st_shift      = '0;
  logic [CountW-1:0] st_body_left  = '0;
  logic [CountW-1:0] st_blob_left  = '0;
  logic [CountW-1:0] st_ents_left  = '0;
  logic [CountW-1:0] st_ent_idx    = '0;
  logic              st_err        = 1'b0;
  logic              st_halted     = 1'b0;

  parse_token_t expected_tokens[$];
  logic [7:0]   body[$];
  int unsigned  blob_ends[$];

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  function automatic string token_text(input parse_token_t t);
    return $sformatf("code %0d value %h entry %0d last %b done %b status %0d",
                     t.code, t.value, t.ent, t.last, t.done, t.status);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[tb] %s", msg);
  endfunction

  function automatic void expect_token(input parse_token_t t);
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void add_body_byte(input logic [7:0] b);
    body.insert(body.size(), b);
  endfunction

  // Bytes in a fixed field modulo eight; eight-byte fields close when the count wraps to zero.
  function automatic logic [FbcW-1:0] field_bytes(input logic [CodeW-1:0] ph);
    case (ph)
      PH_TYPE, PH_REJECT, CODE_ENT_TYPE:             return 3'd1;
      PH_ENT_COUNT, PH_ENT_LEN, PH_SNAP_LEN, PH_CTX_LEN: return 3'd4;
      default:                                       return 3'd0;
    endcase
  endfunction

  function automatic void next_entry();
    st_ent_idx   = st_ent_idx + 1;
    st_ents_left = st_ents_left - 1;
    st_phase     = (st_ents_left != 0) ? PH_ENT_TERM : PH_SNAP_TERM;
  endfunction

  function automatic void open_blob(input logic [ValueW-1:0] blen,
                                    input logic [CodeW-1:0] byte_phase);
    if (blen > 64'(st_body_left)) begin
      st_err = 1'b1;
      return;
    end
    st_blob_left = blen[CountW-1:0];
    if (blen != 0) begin
      st_phase = byte_phase;
    end else if (byte_phase == PH_ENT_BYTE) begin
      next_entry();
    end else begin
      st_phase = byte_phase + 5'd1;
    end
  endfunction

  // Advances the predicted parser by one byte and queues the token it yields, if any.
  task automatic parse_byte(input logic [7:0] b);
    parse_token_t t;
    logic [CountW-1:0] len;
    logic [CodeW-1:0] ph;
    bit has;
    bit final_byte;
    t = '0;
    t.code = CODE_STATUS;
    has = 1'b0;
    if (st_halted) return;
    if (st_phase == PH_PREFIX) begin
      st_shift |= 64'(b) << (8 * st_fbc[1:0]);
      st_fbc = st_fbc + 3'd1;
      if (st_fbc < 4) return;
      len = st_shift[CountW-1:0];
      st_shift = '0;
      st_fbc = '0;
      if (len == 0 || len > max_len) begin
        st_halted = 1'b1;
        t.value = 64'(len);
        t.done = 1'b1;
        t.status = ST_BAD;
        expect_token(t);
        return;
      end
      st_body_left = len;
      st_phase = PH_TYPE;
      st_err = 1'b0;
      return;
    end

    st_body_left = st_body_left - 1;
    final_byte = (st_body_left == 0);
    if (!st_err && st_phase < PH_DONE) begin
      ph = st_phase;
      if (ph >= PH_ENT_TERM && ph <= PH_ENT_BYTE) t.ent = st_ent_idx;
      if (ph == PH_ENT_BYTE || ph == PH_SNAP_BYTE || ph == PH_CTX_BYTE) begin
        has = 1'b1;
        t.code = ph;
        t.value = 64'(b);
        st_blob_left = st_blob_left - 1;
        t.last = (st_blob_left == 0);
        if (t.last) begin
          if (ph == PH_ENT_BYTE) next_entry();
          else st_phase = ph + 5'd1;
        end
      end else begin
        st_shift |= 64'(b) << (8 * st_fbc);
        st_fbc = st_fbc + 3'd1;
        if (st_fbc == field_bytes(ph)) begin
          has = 1'b1;
          t.code = ph;
          t.value = st_shift;
          st_shift = '0;
          st_fbc = '0;
          case (ph)
            PH_REJECT: begin
              t.value = 64'(t.value != 0);
              st_phase = PH_HINT;
            end
            PH_ENT_COUNT: begin
              st_ents_left = t.value[CountW-1:0];
              st_ent_idx = '0;
              st_phase = (st_ents_left != 0) ? PH_ENT_TERM : PH_SNAP_TERM;
            end
            PH_ENT_LEN:  open_blob(t.value, PH_ENT_BYTE);
            PH_SNAP_LEN: open_blob(t.value, PH_SNAP_BYTE);
            PH_CTX_LEN:  open_blob(t.value, PH_CTX_BYTE);
            default:     st_phase = ph + 5'd1;
          endcase
        end
      end
    end

    if (!final_byte) begin
      if (has) expect_token(t);
      return;
    end
    t.done = 1'b1;
    t.status = (st_phase == PH_DONE && !st_err) ? ST_OK : ST_TRUNC;
    // A truncated frame, or a last byte that completes nothing, reports status alone.
    if (t.status == ST_TRUNC || !has) begin
      t.code = CODE_STATUS;
      t.value = '0;
      t.ent = '0;
      t.last = 1'b0;
    end
    expect_token(t);
    st_phase = PH_PREFIX;
    st_fbc = '0;
    st_shift = '0;
    st_blob_left = '0;
    st_ents_left = '0;
    st_ent_idx = '0;
    st_err = 1'b0;
  endtask

  // Result side: random stalls and the comparison against the predicted tokens.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    parse_token_t got;
    parse_token_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.code   = out_tuser;
      got.value  = out_tdata[63:0];
      got.ent    = out_tdata[95:64];
      got.last   = out_tdata[96];
      got.status = out_tdata[98:97];
      got.done   = out_tlast;
      if (expected_tokens.size() == 0) begin
        note_failure({"unexpected token: ", token_text(got)});
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want)
          note_failure({"token mismatch: expected ", token_text(want),
                        "; actual ", token_text(got)});
      end
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[framed_message_parser_core] ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_frame(input logic [CountW-1:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
    for (int i = 0; i < body.size() && i < len; i++) send_byte(body[i]);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit wr, input logic [AddrW-1:0] addr,
                              input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register, then reads back the frame length limit and checks it.
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    logic [DataW-1:0] rd;
    apb_transfer(1'b1, addr, data, rd);
    if (addr[2] == REG_MAX_LEN) max_len = data;
    apb_transfer(1'b0, ADDR_MAX_LEN, '0, rd);
    if (rd !== max_len)
      note_failure($sformatf("length limit readback: expected %h actual %h", max_len, rd));
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void put_field(input logic [ValueW-1:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) add_body_byte(v[8*i +: 8]);
  endfunction

  function automatic void put_blob();
    int unsigned n;
    n = ($urandom_range(7) == 0) ? $urandom_range(4, 12) : $urandom_range(3);
    put_field(64'(n), 4);
    blob_ends.insert(blob_ends.size(), body.size());
    repeat (n) add_body_byte(8'($urandom));
  endfunction

  // Builds a message body whose entry count field may differ from the entries present.
  function automatic void build_message(input logic [CountW-1:0] ent_count,
                                        input int unsigned ents_built);
    body.delete();
    blob_ends.delete();
    put_field(rand_value(), 1);
    repeat (6) put_field(rand_value(), 8);
    put_field(($urandom_range(3) == 0) ? 64'd0 : rand_value(), 1);
    put_field(rand_value(), 8);
    put_field(64'(ent_count), 4);
    repeat (ents_built) begin
      put_field(rand_value(), 8);
      put_field(rand_value(), 8);
      put_field(rand_value(), 1);
      put_blob();
    end
    put_field(rand_value(), 8);
    put_field(rand_value(), 8);
    put_blob();
    put_blob();
  endfunction

  task automatic send_random_frame();
    frame_kind_t kind;
    int unsigned pick;
    int unsigned n;
    int unsigned pos;
    logic [CountW-1:0] len;
    logic [CountW-1:0] bad;
    pick = $urandom_range(99);
    if (pick < 40)      kind = FR_EXACT;
    else if (pick < 55) kind = FR_TRAILING;
    else if (pick < 70) kind = FR_TRUNCATED;
    else if (pick < 80) kind = FR_BLOB_OVERRUN;
    else if (pick < 88) kind = FR_HUGE_COUNT;
    else                kind = FR_NOISE;

    case (kind)
      FR_NOISE: begin
        body.delete();
        repeat ($urandom_range(1, 24)) add_body_byte(8'($urandom));
      end
      FR_HUGE_COUNT: build_message($urandom, 2);
      default: begin
        n = $urandom_range(2);
        build_message(n, n);
      end
    endcase
    len = body.size();
    case (kind)
      FR_TRAILING: begin
        repeat ($urandom_range(1, 6)) add_body_byte(8'($urandom));
        len = body.size();
      end
      FR_TRUNCATED: len = $urandom_range(1, body.size() - 1);
      FR_BLOB_OVERRUN: begin
        // Claim more blob bytes than the frame has left after the length field.
        pos = blob_ends[$urandom_range(blob_ends.size() - 1)];
        bad = $urandom_range(1) ? (body.size() - pos + $urandom_range(1, 3))
                                : ($urandom | 32'h8000_0000);
        for (int i = 0; i < 4; i++) body[pos - 4 + i] = bad[8*i +: 8];
      end
      default: ;
    endcase
    send_frame(len);
  endtask

  task automatic test_config_regs();
    write_reg(ADDR_SPARE, $urandom);
    write_reg(ADDR_MAX_LEN, $urandom);
    write_reg(ADDR_MAX_LEN, MAX_LEN_RESET);
  endtask

  // Limit of one byte: every frame is a single type byte and ends truncated.
  task automatic test_single_byte_frames();
    write_reg(ADDR_MAX_LEN, 32'd1);
    body.delete();
    add_body_byte(8'h00);
    send_frame(32'd1);
    body[0] = 8'hFF;
    send_frame(32'd1);
    body[0] = 8'($urandom);
    send_frame(32'd1);
    wait_idle();
  endtask

  task automatic test_frame_mix(input int unsigned idle_pct, input int unsigned stall_pct,
                                input logic [CountW-1:0] limit);
    int unsigned start;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    write_reg(ADDR_MAX_LEN, limit);
    start = bytes_sent;
    while (bytes_sent - start < MIX_BYTES) send_random_frame();
    wait_idle();
  endtask

  // A rejected length stops the parser for good, so this runs last.
  task automatic test_halt();
    halt_cause_t cause;
    logic [CountW-1:0] limit;
    logic [CountW-1:0] len;
    cause = halt_cause_t'($urandom_range(2));
    case (cause)
      HALT_ZERO_LEN: len = '0;
      HALT_OVER_LIMIT: begin
        limit = $urandom_range(200, 32'hFFFF_FFFE);
        write_reg(ADDR_MAX_LEN, limit);
        len = limit + 1;
        if ($urandom_range(1)) len = len + $urandom_range(0, 32'hFFFF_FFFF - limit - 1);
      end
      default: begin
        write_reg(ADDR_MAX_LEN, '0);
        len = $urandom;
      end
    endcase
    body.delete();
    send_frame(len);
    repeat (24) send_byte(8'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_config_regs();
    test_single_byte_frames();
    test_frame_mix(0, 0, 32'hFFFF_FFFF);
    test_frame_mix(64, 0, MAX_LEN_RESET);
    test_frame_mix(0, 64, $urandom_range(200, 1000));
    test_frame_mix(17, 17, $urandom_range(200, 32'hFFFF_FFFF));
    test_halt();
    if (fail_count == 0) begin
      $display("[framed_message_parser_core] OK");
    end else begin
      $display("[framed_message_parser_core] ERROR");
    end
    $finish;
  end

endmodule
